>>> rtl/nmmc_pkg.sv
// nmmc_pkg: shared types, field widths, codes and constants for the
// nucleosome mark monte carlo step block
// no dependencies; compiled first
`default_nettype none

package nmmc_pkg;

    localparam int IDX_W      = 6;
    localparam int MARK_W     = 2;
    localparam int DRAW_W     = 16;
    localparam int COUNT_W    = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int NUM_MARKS  = 3;

    localparam int DEFAULT_MAX_SITES = 64;

    // opcodes; the fourth code is invalid
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_STEP  = 2'd2;

    // mark states
    localparam logic [MARK_W-1:0] MARK_UNMOD   = 2'd0;
    localparam logic [MARK_W-1:0] MARK_INTER   = 2'd1;
    localparam logic [MARK_W-1:0] MARK_MOD     = 2'd2;
    localparam logic [MARK_W-1:0] MARK_INVALID = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SITES_IN_USE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECRUIT_THRESHOLD = 2'd1;

    localparam logic [COUNT_W-1:0] SITES_IN_USE_RESET      = 7'd60;
    localparam logic [DRAW_W-1:0]  RECRUIT_THRESHOLD_RESET = 16'd18725;

    // q0.16 draw d is below 1/3 when d < ceil(65536/3), below 2/3 when d < ceil(131072/3)
    localparam int DRAW_SCALE = 65536;
    localparam logic [DRAW_W-1:0] THIRD_LIMIT      = DRAW_W'((DRAW_SCALE + 2) / 3);
    localparam logic [DRAW_W-1:0] TWO_THIRDS_LIMIT = DRAW_W'((2 * DRAW_SCALE + 2) / 3);

    localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_ZERO = '0;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [IDX_W-1:0]  site_index;
        logic [IDX_W-1:0]  partner_index;
        logic [MARK_W-1:0] load_state;
        logic [DRAW_W-1:0] recruit_draw;
        logic [DRAW_W-1:0] noise_draw;
    } item_t;

    typedef struct packed {
        logic [MARK_W-1:0]  site_state;
        logic               changed;
        logic [COUNT_W-1:0] count_unmodified;
        logic [COUNT_W-1:0] count_intermediate;
        logic [COUNT_W-1:0] count_modified;
        logic               error;
    } result_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } cfg_write_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } ctrl_cmd_t;

    typedef enum logic {
        FSM_IDLE,
        FSM_EXEC
    } fsm_state_t;

endpackage

`default_nettype wire

>>> rtl/nmmc_chan_if.sv
// nmmc_chan_if: valid/ready channel with a typed payload
// used by every channel of the top level; payload types come from nmmc_pkg
`default_nettype none

interface nmmc_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/nmmc_ctrl.sv
// nmmc_ctrl: request sequencer and result-register valid flag
// depends on nmmc_pkg
`default_nettype none

module nmmc_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    output nmmc_pkg::ctrl_cmd_t       cmd
);

    nmmc_pkg::fsm_state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nmmc_pkg::FSM_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = nmmc_pkg::FSM_EXEC;
                end
            end
            nmmc_pkg::FSM_EXEC:
            begin
                // hold the fetched marks until the result register has room
                if (slot_free)
                begin
                    state_next = nmmc_pkg::FSM_IDLE;
                end
            end
            default:
            begin
                state_next = nmmc_pkg::FSM_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            nmmc_pkg::FSM_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            nmmc_pkg::FSM_EXEC:
            begin
                cmd.commit = slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nmmc_pkg::FSM_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/nmmc_datapath.sv
// nmmc_datapath: site store, state counts, config registers, update logic
// and result register; depends on nmmc_pkg, driven by nmmc_ctrl commands
`default_nettype none

module nmmc_datapath #(
    parameter int MAX_SITES = nmmc_pkg::DEFAULT_MAX_SITES
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire nmmc_pkg::ctrl_cmd_t    cmd,
    input  wire nmmc_pkg::item_t        item,
    input  wire logic                   cfg_we,
    input  wire nmmc_pkg::cfg_write_t   cfg_wr,
    output nmmc_pkg::result_t           result
);

    localparam int AW = $clog2(MAX_SITES);
    localparam int IW = nmmc_pkg::IDX_W;
    localparam int MW = nmmc_pkg::MARK_W;
    localparam int CW = nmmc_pkg::COUNT_W;

    function automatic logic [AW-1:0] to_addr(input logic [IW-1:0] idx);
        logic [AW+IW-1:0] ext;
        begin
            ext = {{AW{1'b0}}, idx};
            return ext[AW-1:0];
        end
    endfunction

    function automatic logic [MW-1:0] next_mark(
        input logic [MW-1:0]               s1,
        input logic [MW-1:0]               s2,
        input logic [nmmc_pkg::DRAW_W-1:0] rdraw,
        input logic [nmmc_pkg::DRAW_W-1:0] ndraw,
        input logic [nmmc_pkg::DRAW_W-1:0] thr
    );
        logic [MW-1:0] ns;
        begin
            ns = s1;
            if (rdraw < thr)
            begin
                // recruited: move one step toward partner, partner in state 1 does nothing
                if (s1 != s2 && s2 == nmmc_pkg::MARK_MOD)
                begin
                    ns = s1 + MW'(1);
                end
                else if (s1 != s2 && s2 == nmmc_pkg::MARK_UNMOD)
                begin
                    ns = s1 - MW'(1);
                end
            end
            else
            begin
                priority if (s1 == nmmc_pkg::MARK_UNMOD)
                begin
                    ns = (ndraw < nmmc_pkg::THIRD_LIMIT) ? nmmc_pkg::MARK_INTER
                                                         : nmmc_pkg::MARK_UNMOD;
                end
                else if (s1 == nmmc_pkg::MARK_INTER)
                begin
                    if (ndraw < nmmc_pkg::THIRD_LIMIT)
                    begin
                        ns = nmmc_pkg::MARK_MOD;
                    end
                    else if (ndraw < nmmc_pkg::TWO_THIRDS_LIMIT)
                    begin
                        ns = nmmc_pkg::MARK_UNMOD;
                    end
                end
                else if (s1 == nmmc_pkg::MARK_MOD)
                begin
                    ns = (ndraw < nmmc_pkg::THIRD_LIMIT) ? nmmc_pkg::MARK_INTER
                                                         : nmmc_pkg::MARK_MOD;
                end
                else
                begin
                    ns = s1;
                end
            end
            return ns;
        end
    endfunction

    logic [MW-1:0] site_mem [MAX_SITES];

    logic [CW-1:0]               sites_in_use_reg;
    logic [nmmc_pkg::DRAW_W-1:0] recruit_threshold_reg;
    nmmc_pkg::item_t             item_reg;
    logic [MW-1:0]               site_mark_reg;
    logic [MW-1:0]               partner_mark_reg;
    logic [CW-1:0]               count_reg  [nmmc_pkg::NUM_MARKS];
    logic [CW-1:0]               count_next [nmmc_pkg::NUM_MARKS];
    nmmc_pkg::result_t           result_reg;
    nmmc_pkg::result_t           result_next;

    logic                        site_ok;
    logic                        partner_ok;
    logic [MW-1:0]               new_mark;
    logic [MW-1:0]               out_mark;
    logic                        err;
    logic                        chg;
    logic                        clr;
    logic                        wr_req;
    logic [MW-1:0]               wr_data;
    logic [nmmc_pkg::NUM_MARKS-1:0] inc;
    logic [nmmc_pkg::NUM_MARKS-1:0] dec;

    assign site_ok = ({1'b0, item_reg.site_index} < sites_in_use_reg)
                  && (32'(item_reg.site_index) < 32'(MAX_SITES));
    assign partner_ok = ({1'b0, item_reg.partner_index} < sites_in_use_reg)
                     && (32'(item_reg.partner_index) < 32'(MAX_SITES));

    assign new_mark = next_mark(site_mark_reg, partner_mark_reg, item_reg.recruit_draw,
                                item_reg.noise_draw, recruit_threshold_reg);

    always_comb
    begin
        err      = 1'b0;
        chg      = 1'b0;
        clr      = 1'b0;
        wr_req   = 1'b0;
        wr_data  = item_reg.load_state;
        out_mark = nmmc_pkg::MARK_UNMOD;
        inc      = '0;
        dec      = '0;
        unique case (item_reg.opcode)
            nmmc_pkg::OP_CLEAR:
            begin
                clr = 1'b1;
            end
            nmmc_pkg::OP_LOAD:
            begin
                if (!site_ok || item_reg.load_state == nmmc_pkg::MARK_INVALID)
                begin
                    err = 1'b1;
                end
                else
                begin
                    wr_req   = 1'b1;
                    wr_data  = item_reg.load_state;
                    out_mark = item_reg.load_state;
                    // old mark's count is left alone on a reload
                    for (int i = 0; i < nmmc_pkg::NUM_MARKS; i++)
                    begin
                        inc[i] = (item_reg.load_state == MW'(i));
                    end
                end
            end
            nmmc_pkg::OP_STEP:
            begin
                if (!site_ok || !partner_ok || item_reg.site_index == item_reg.partner_index)
                begin
                    err = 1'b1;
                end
                else
                begin
                    out_mark = site_mark_reg;
                    if (new_mark != site_mark_reg && new_mark != nmmc_pkg::MARK_INVALID)
                    begin
                        chg      = 1'b1;
                        wr_req   = 1'b1;
                        wr_data  = new_mark;
                        out_mark = new_mark;
                        for (int i = 0; i < nmmc_pkg::NUM_MARKS; i++)
                        begin
                            inc[i] = (new_mark == MW'(i));
                            dec[i] = (site_mark_reg == MW'(i));
                        end
                    end
                end
            end
            default:
            begin
                err = 1'b1;
            end
        endcase
    end

    // saturating counts; inc and dec never hit the same count
    always_comb
    begin
        for (int i = 0; i < nmmc_pkg::NUM_MARKS; i++)
        begin
            priority if (clr)
            begin
                count_next[i] = nmmc_pkg::COUNT_ZERO;
            end
            else if (inc[i] && count_reg[i] != nmmc_pkg::COUNT_MAX)
            begin
                count_next[i] = count_reg[i] + CW'(1);
            end
            else if (dec[i] && count_reg[i] != nmmc_pkg::COUNT_ZERO)
            begin
                count_next[i] = count_reg[i] - CW'(1);
            end
            else
            begin
                count_next[i] = count_reg[i];
            end
        end
    end

    always_comb
    begin
        result_next.site_state         = out_mark;
        result_next.changed            = chg;
        result_next.count_unmodified   = count_next[0];
        result_next.count_intermediate = count_next[1];
        result_next.count_modified     = count_next[2];
        result_next.error              = err;
    end

    // store: one write port, two registered read ports sampled at request capture
    always_ff @(posedge clk)
    begin
        if (cmd.commit && wr_req)
        begin
            site_mem[to_addr(item_reg.site_index)] <= wr_data;
        end
        if (cmd.capture)
        begin
            site_mark_reg    <= site_mem[to_addr(item.site_index)];
            partner_mark_reg <= site_mem[to_addr(item.partner_index)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
        end
        if (cmd.commit)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < nmmc_pkg::NUM_MARKS; i++)
            begin
                count_reg[i] <= nmmc_pkg::COUNT_ZERO;
            end
        end
        else if (cmd.commit)
        begin
            for (int i = 0; i < nmmc_pkg::NUM_MARKS; i++)
            begin
                count_reg[i] <= count_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sites_in_use_reg      <= nmmc_pkg::SITES_IN_USE_RESET;
            recruit_threshold_reg <= nmmc_pkg::RECRUIT_THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_wr.index)
                nmmc_pkg::CFG_SITES_IN_USE:
                begin
                    sites_in_use_reg <= cfg_wr.value[CW-1:0];
                end
                nmmc_pkg::CFG_RECRUIT_THRESHOLD:
                begin
                    recruit_threshold_reg <= cfg_wr.value[nmmc_pkg::DRAW_W-1:0];
                end
                default:
                begin
                    sites_in_use_reg <= sites_in_use_reg;
                end
            endcase
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

>>> rtl/nucleosome_mark_monte_carlo_step_top.sv
// nucleosome_mark_monte_carlo_step_top: three-state mark store with one
// monte carlo update per request; depends on nmmc_pkg, nmmc_chan_if,
// nmmc_ctrl and nmmc_datapath
//
//   channel   dir   payload              handshake
//   items     in    nmmc_pkg::item_t     valid/ready
//   results   out   nmmc_pkg::result_t   valid/ready
//   cfg       in    nmmc_pkg::cfg_write_t valid/ready, ready tied high
//
// per request: the accept edge reads site and partner from the store's two
// read ports into registers; a later commit edge writes the store back,
// updates the counts and loads the result register
// while the result register is full and not taken, the block holds in its
// exec state and items.ready stays low
// reset clears the counts and loads 60 and 18725 into the config registers;
// the store is not cleared and holds nothing valid until sites are loaded
`default_nettype none

module nucleosome_mark_monte_carlo_step_top #(
    parameter int MAX_SITES = nmmc_pkg::DEFAULT_MAX_SITES
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    nmmc_chan_if.sink   items,
    nmmc_chan_if.source results,
    nmmc_chan_if.sink   cfg
);

    nmmc_pkg::ctrl_cmd_t cmd;
    nmmc_pkg::result_t   result;

    assign cfg.ready = 1'b1;

    nmmc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (items.valid),
        .in_ready  (items.ready),
        .out_ready (results.ready),
        .out_valid (results.valid),
        .cmd       (cmd)
    );

    nmmc_datapath #(
        .MAX_SITES (MAX_SITES)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (items.data),
        .cfg_we (cfg.valid),
        .cfg_wr (cfg.data),
        .result (result)
    );

    assign results.data = result;

    // one request in flight: no accept on the edge right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        items.valid && items.ready |=> !items.ready)
        else $error("request accepted while previous one still in work");

    // a committed request always shows up as a pending result
    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> results.valid)
        else $error("committed result not presented");

    // commit only happens for a captured request, never in the same cycle as a capture
    a_commit_after_capture: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> !cmd.commit)
        else $error("capture and commit in the same cycle");

    // error results carry no state and no change
    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.data.error |->
            results.data.site_state == nmmc_pkg::MARK_UNMOD && !results.data.changed)
        else $error("error result with nonzero state or change flag");

endmodule

`default_nettype wire

>>> test/nmmc_result_checker.sv
// nmmc_result_checker: watches the item, result and register channels of the
// mark store block, predicts every result and compares it field by field
// depends on nmmc_pkg for the payload types and codes

module nmmc_result_checker
    import nmmc_pkg::*;
#(
    parameter int MAX_SITES = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic       item_ready,
    input  item_t      item_data,
    input  logic       result_valid,
    input  logic       result_ready,
    input  result_t    result_data,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  cfg_write_t cfg_data,
    output int         mismatches,
    output int         pending,
    output int         site_changes,
    output int         error_results
);

    // q0.16 draw is below 1/3 when d < 21846, below 2/3 when d < 43691
    localparam int ONE_THIRD_DRAW  = 21846;
    localparam int TWO_THIRDS_DRAW = 43691;
    localparam logic [COUNT_W-1:0] COUNT_TOP = 7'd127;

    logic [MARK_W-1:0]  mark_store [MAX_SITES];
    logic [COUNT_W-1:0] mark_counts [NUM_MARKS];
    logic [COUNT_W-1:0] sites_in_use;
    logic [DRAW_W-1:0]  recruit_threshold;
    result_t            mark_results_due [$];
    int                 mismatch_total;
    int                 change_total;
    int                 error_total;

    function automatic void count_up(input logic [MARK_W-1:0] mark);
        if (mark < NUM_MARKS && mark_counts[mark] < COUNT_TOP)
            mark_counts[mark] = mark_counts[mark] + 1'b1;
    endfunction

    function automatic void count_down(input logic [MARK_W-1:0] mark);
        if (mark < NUM_MARKS && mark_counts[mark] != '0)
            mark_counts[mark] = mark_counts[mark] - 1'b1;
    endfunction

    function automatic result_t apply_mark_request(input item_t req);
        result_t           r;
        int                limit;
        logic [MARK_W-1:0] cur;
        logic [MARK_W-1:0] ptn;
        logic [MARK_W-1:0] nxt;
        r = '0;
        limit = (sites_in_use < MAX_SITES) ? int'(sites_in_use) : MAX_SITES;
        case (req.opcode)
            OP_CLEAR:
            begin
                for (int i = 0; i < NUM_MARKS; i++)
                    mark_counts[i] = '0;
            end
            OP_LOAD:
            begin
                if (req.site_index >= limit || req.load_state == MARK_INVALID)
                    r.error = 1'b1;
                else
                begin
                    mark_store[req.site_index] = req.load_state;
                    count_up(req.load_state);
                    r.site_state = req.load_state;
                end
            end
            OP_STEP:
            begin
                if (req.site_index >= limit || req.partner_index >= limit ||
                    req.site_index == req.partner_index)
                    r.error = 1'b1;
                else
                begin
                    cur = mark_store[req.site_index];
                    ptn = mark_store[req.partner_index];
                    if (req.recruit_draw < recruit_threshold)
                    begin
                        // recruited: move one step toward a fully set or fully unmodified partner
                        if (cur != ptn && ptn == MARK_MOD)
                            nxt = cur + 1'b1;
                        else if (cur != ptn && ptn == MARK_UNMOD)
                            nxt = cur - 1'b1;
                        else
                            nxt = cur;
                    end
                    else
                    begin
                        case (cur)
                            MARK_UNMOD:
                                nxt = (req.noise_draw < ONE_THIRD_DRAW) ? MARK_INTER : MARK_UNMOD;
                            MARK_INTER:
                            begin
                                if (req.noise_draw < ONE_THIRD_DRAW)
                                    nxt = MARK_MOD;
                                else if (req.noise_draw < TWO_THIRDS_DRAW)
                                    nxt = MARK_UNMOD;
                                else
                                    nxt = MARK_INTER;
                            end
                            default:
                                nxt = (req.noise_draw < ONE_THIRD_DRAW) ? MARK_INTER : cur;
                        endcase
                    end
                    if (nxt != cur)
                    begin
                        count_down(cur);
                        mark_store[req.site_index] = nxt;
                        count_up(nxt);
                        r.changed = 1'b1;
                        change_total++;
                    end
                    r.site_state = mark_store[req.site_index];
                end
            end
            default:
                r.error = 1'b1;
        endcase
        r.count_unmodified   = mark_counts[0];
        r.count_intermediate = mark_counts[1];
        r.count_modified     = mark_counts[2];
        if (r.error)
            error_total++;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_total++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SITES; i++)
                mark_store[i] = '0;
            for (int i = 0; i < NUM_MARKS; i++)
                mark_counts[i] = '0;
            sites_in_use = 7'd60;
            recruit_threshold = 16'd18725;
            mark_results_due.delete();
            mismatch_total = 0;
            change_total = 0;
            error_total = 0;
            mismatches <= 0;
            pending <= 0;
            site_changes <= 0;
            error_results <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (mark_results_due.size() == 0)
                begin
                    $display("%0t: result with no request outstanding, got %p",
                             $time, result_data);
                    mismatch_total++;
                end
                else
                begin
                    want = mark_results_due.pop_front();
                    check_field("site_state", 8'(want.site_state), 8'(result_data.site_state));
                    check_field("changed", 8'(want.changed), 8'(result_data.changed));
                    check_field("count_unmodified", 8'(want.count_unmodified),
                                8'(result_data.count_unmodified));
                    check_field("count_intermediate", 8'(want.count_intermediate),
                                8'(result_data.count_intermediate));
                    check_field("count_modified", 8'(want.count_modified),
                                8'(result_data.count_modified));
                    check_field("error", 8'(want.error), 8'(result_data.error));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_data.index == CFG_SITES_IN_USE)
                    sites_in_use = cfg_data.value[COUNT_W-1:0];
                else if (cfg_data.index == CFG_RECRUIT_THRESHOLD)
                    recruit_threshold = cfg_data.value;
            end
            if (item_valid && item_ready)
                mark_results_due.push_back(apply_mark_request(item_data));
            mismatches <= mismatch_total;
            pending <= mark_results_due.size();
            site_changes <= change_total;
            error_results <= error_total;
        end
    end

endmodule

>>> test/nucleosome_mark_monte_carlo_step_top_test.sv
// nucleosome_mark_monte_carlo_step_top_test: drives requests and register
// writes into the mark store block and gives the verdict
// depends on nmmc_pkg, nmmc_chan_if, the block and nmmc_result_checker

module nucleosome_mark_monte_carlo_step_top_test;
    import nmmc_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int RECEIVER_HOLD = 150;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    nmmc_chan_if #(.payload_t(item_t))      items_ch ();
    nmmc_chan_if #(.payload_t(result_t))    results_ch ();
    nmmc_chan_if #(.payload_t(cfg_write_t)) cfg_ch ();

    int          mismatches;
    int          pending;
    int          site_changes;
    int          error_results;

    bit          written [64];
    int          limit = 60;
    logic [15:0] cur_threshold = 16'd18725;
    bit          quiet = 1'b0;
    int          requests_sent = 0;
    int          settings_used = 0;

    nucleosome_mark_monte_carlo_step_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_ch),
        .results (results_ch),
        .cfg     (cfg_ch)
    );

    nmmc_result_checker result_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (items_ch.valid),
        .item_ready    (items_ch.ready),
        .item_data     (items_ch.data),
        .result_valid  (results_ch.valid),
        .result_ready  (results_ch.ready),
        .result_data   (results_ch.data),
        .cfg_valid     (cfg_ch.valid),
        .cfg_ready     (cfg_ch.ready),
        .cfg_data      (cfg_ch.data),
        .mismatches    (mismatches),
        .pending       (pending),
        .site_changes  (site_changes),
        .error_results (error_results)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic item_t make_request(input logic [1:0] op, input int site,
                                           input int partner, input logic [1:0] mark,
                                           input int rdraw, input int ndraw);
        item_t it;
        it.opcode        = op;
        it.site_index    = 6'(site);
        it.partner_index = 6'(partner);
        it.load_state    = mark;
        it.recruit_draw  = 16'(rdraw);
        it.noise_draw    = 16'(ndraw);
        return it;
    endfunction

    // draws lean on the edges: zero, full scale, the threshold, one third, two thirds
    function automatic logic [15:0] random_draw();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return cur_threshold;
            3: return cur_threshold - 1'b1;
            4: return 16'($urandom_range(21844, 21847));
            5: return 16'($urandom_range(43689, 43692));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic item_t random_request();
        item_t it;
        int    pick;
        int    pool [$];
        int    a;
        int    b;
        it = make_request(OP_STEP, $urandom_range(0, 63), $urandom_range(0, 63),
                          2'($urandom_range(0, 3)), random_draw(), random_draw());
        for (int i = 0; i < limit; i++)
            if (written[i])
                pool.push_back(i);
        pick = $urandom_range(0, 99);
        if (pick < 3)
            it.opcode = OP_CLEAR;
        else if (pick < 5)
            it.opcode = OP_UNUSED;
        else if (pick < 30 || pool.size() < 2)
        begin
            it.opcode = OP_LOAD;
            if ($urandom_range(0, 9) != 0)
                it.site_index = 6'($urandom_range(0, limit - 1));
            if ($urandom_range(0, 9) != 0)
                it.load_state = 2'($urandom_range(0, 2));
        end
        else if (pick < 38)
        begin
            // malformed step; never let it read a site that holds nothing yet
            if (it.site_index < limit && it.partner_index < limit &&
                it.site_index != it.partner_index &&
                !(written[it.site_index] && written[it.partner_index]))
                it.partner_index = it.site_index;
        end
        else
        begin
            a = $urandom_range(0, pool.size() - 1);
            b = $urandom_range(0, pool.size() - 2);
            if (b >= a)
                b++;
            it.site_index = 6'(pool[a]);
            it.partner_index = 6'(pool[b]);
        end
        return it;
    endfunction

    task automatic send_item(input item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            items_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        items_ch.valid <= 1'b1;
        items_ch.data <= it;
        if (it.opcode == OP_LOAD && it.site_index < limit && it.load_state != MARK_INVALID)
            written[it.site_index] = 1'b1;
        requests_sent++;
        @(posedge clk);
        while (!items_ch.ready)
            @(posedge clk);
    endtask

    // stop offering and wait until every predicted result has come back
    task automatic drain();
        items_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_settings(input int sites, input int thr);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= cfg_write_t'{index: CFG_SITES_IN_USE, value: 16'(sites)};
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.data <= cfg_write_t'{index: CFG_RECRUIT_THRESHOLD, value: 16'(thr)};
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        limit = (sites > 64) ? 64 : sites;
        cur_threshold = 16'(thr);
        settings_used++;
    endtask

    task automatic run_phase(input int sites, input int thr, input int n, input bit no_gaps);
        drain();
        write_settings(sites, thr);
        quiet = no_gaps;
        repeat (n) send_item(random_request());
    endtask

    task automatic directed_requests();
        send_item(make_request(OP_STEP, 61, 0, MARK_UNMOD, 0, 0));
        send_item(make_request(OP_UNUSED, 63, 63, MARK_INVALID, 65535, 65535));
        send_item(make_request(OP_LOAD, 0, 0, MARK_UNMOD, 0, 0));
        send_item(make_request(OP_LOAD, 1, 0, MARK_MOD, 0, 0));
        send_item(make_request(OP_LOAD, 2, 0, MARK_INTER, 0, 0));
        send_item(make_request(OP_LOAD, 3, 0, MARK_INVALID, 0, 0));
        send_item(make_request(OP_LOAD, 60, 0, MARK_UNMOD, 0, 0));
        // recruited toward a modified partner, twice, then already equal
        send_item(make_request(OP_STEP, 0, 1, MARK_UNMOD, 0, 65535));
        send_item(make_request(OP_STEP, 0, 1, MARK_UNMOD, 18724, 65535));
        send_item(make_request(OP_STEP, 0, 1, MARK_UNMOD, 0, 0));
        // intermediate partner does not recruit
        send_item(make_request(OP_STEP, 1, 2, MARK_UNMOD, 0, 0));
        send_item(make_request(OP_LOAD, 4, 0, MARK_UNMOD, 0, 0));
        send_item(make_request(OP_STEP, 1, 4, MARK_UNMOD, 0, 65535));
        // noisy path around both thirds
        send_item(make_request(OP_STEP, 2, 1, MARK_UNMOD, 18725, 0));
        send_item(make_request(OP_STEP, 2, 1, MARK_UNMOD, 65535, 21845));
        send_item(make_request(OP_STEP, 2, 1, MARK_UNMOD, 65535, 21846));
        send_item(make_request(OP_STEP, 2, 1, MARK_UNMOD, 65535, 43690));
        send_item(make_request(OP_STEP, 2, 1, MARK_UNMOD, 65535, 21845));
        send_item(make_request(OP_STEP, 2, 1, MARK_UNMOD, 65535, 43691));
        send_item(make_request(OP_STEP, 4, 1, MARK_UNMOD, 65535, 65535));
        send_item(make_request(OP_STEP, 0, 0, MARK_UNMOD, 0, 0));
        send_item(make_request(OP_STEP, 0, 61, MARK_UNMOD, 0, 0));
        send_item(make_request(OP_CLEAR, 0, 0, MARK_UNMOD, 0, 0));
        // decrement of an empty count stays at zero
        send_item(make_request(OP_STEP, 1, 4, MARK_UNMOD, 0, 0));
    endtask

    initial
    begin
        items_ch.valid <= 1'b0;
        items_ch.data <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_requests();

        // fill every site, then push the modified count into saturation
        drain();
        write_settings(64, 18725);
        for (int i = 0; i < 64; i++)
            send_item(make_request(OP_LOAD, i, $urandom_range(0, 63),
                                   ($urandom_range(0, 1) != 0) ? MARK_MOD
                                                               : 2'($urandom_range(0, 1)),
                                   random_draw(), random_draw()));
        repeat (100)
            send_item(make_request(OP_LOAD, $urandom_range(0, 63), $urandom_range(0, 63),
                                   MARK_MOD, random_draw(), random_draw()));

        run_phase(64, 0, 50, 1'b1);
        run_phase(64, 65535, 50, 1'b0);
        run_phase(2, $urandom_range(0, 65535), 40, 1'b0);
        run_phase($urandom_range(2, 64), $urandom_range(0, 65535), 60, 1'b0);
        run_phase($urandom_range(2, 64), $urandom_range(0, 65535), 60, 1'b0);

        drain();
        repeat (10) @(posedge clk);
        $display("covered %0d requests over %0d register settings", requests_sent,
                 settings_used + 1);
        $display("%0d steps changed a site, %0d requests were flagged as errors",
                 site_changes, error_results);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // result side: random gaps, one long hold-off once 100 results have been taken
    initial
    begin
        int gap;
        int taken;
        bit held;
        taken = 0;
        held = 1'b0;
        results_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!held && taken >= 100)
            begin
                held = 1'b1;
                gap = RECEIVER_HOLD;
            end
            else
                gap = pick_gap();
            if (gap > 0)
            begin
                results_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            results_ch.ready <= 1'b1;
            @(posedge clk);
            while (!results_ch.valid)
                @(posedge clk);
            taken++;
        end
    end

    initial
    begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
        $display("FAILURE");
        $finish;
    end

endmodule

>>> filelist.f
rtl/nmmc_pkg.sv
rtl/nmmc_chan_if.sv
rtl/nmmc_ctrl.sv
rtl/nmmc_datapath.sv
rtl/nucleosome_mark_monte_carlo_step_top.sv
test/nmmc_result_checker.sv
test/nucleosome_mark_monte_carlo_step_top_test.sv
